// ===== hw/rtl/dtlr_pkg.sv =====
// ----------------------------------------------------------------------------
// Depth-tested line rasterizer package
// Shared types, field widths and default constants for the rasterizer block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtlr_pkg;

  // Default geometry and accumulator settings.
  localparam int unsigned SCREEN_WIDTH_DEF       = 256;
  localparam int unsigned SCREEN_HEIGHT_DEF      = 256;
  localparam int unsigned VERTEX_COUNT_DEF       = 1024;
  localparam int unsigned STEP_FRACTION_BITS_DEF = 16;

  // Fixed field widths.
  localparam int unsigned POS_W     = 12;
  localparam int unsigned VIDX_W    = 10;
  localparam int unsigned DEPTH_W   = 16;
  localparam int unsigned COLOR_W   = 16;
  localparam int unsigned CNT_W     = 9;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 1;

  // Internal arithmetic widths.
  localparam int unsigned VTX_W     = 2 * POS_W + DEPTH_W;
  localparam int unsigned MUL_W     = DEPTH_W + CFG_W;
  localparam int unsigned LEN_W     = POS_W;
  localparam int unsigned DIV_NUM_W = 40;
  localparam int unsigned ZACC_W    = 48;
  localparam int unsigned PIX_W     = DEPTH_W + COLOR_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_SCALE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_OFFSET = 1'b1;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_LINE  = 2'd1,
    MODE_POINT = 2'd2,
    MODE_READ  = 2'd3
  } mode_e;

  // Command beat.
  typedef struct packed {
    mode_e               mode;
    logic [VIDX_W-1:0]   vertex_a;
    logic [VIDX_W-1:0]   vertex_b;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
    logic [DEPTH_W-1:0]  depth_in;
    logic [COLOR_W-1:0]  color_in;
  } cmd_t;

  // Result beat.
  typedef struct packed {
    logic [CNT_W-1:0]    pixels_written;
    logic                skipped;
    logic [COLOR_W-1:0]  read_color;
    logic [DEPTH_W-1:0]  read_depth;
  } result_t;

  // Classified command as held in the queue.
  typedef struct packed {
    cmd_t cmd;
    logic va_ok;
    logic vb_ok;
    logic on_screen;
  } job_t;

  // Queue head seen by the back end.
  typedef struct packed {
    logic valid;
    job_t job;
  } head_t;

  // Back end status toward the front end.
  typedef struct packed {
    logic pop;
    logic clearing;
  } back_stat_t;

endpackage

// ===== hw/rtl/dtlr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtlr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/dtlr_div.sv =====
// ----------------------------------------------------------------------------
// Rasterizer divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtlr_div #(
  parameter int unsigned NUM_W = 40,
  parameter int unsigned DEN_W = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o,
  output logic             rem_nz_o
);

  localparam int unsigned CW = $clog2(NUM_W);

  logic [DEN_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;
  logic [DEN_W:0]   trial;
  logic             qbit;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    trial = {rem_q, quo_q[NUM_W-1]};
    qbit  = (trial >= {1'b0, den_i});
    rem_d = qbit ? DEN_W'(trial - {1'b0, den_i}) : trial[DEN_W-1:0];
    quo_d = {quo_q[NUM_W-2:0], qbit};
  end

  // Control: step counter and busy/done flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NUM_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and quotient.
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      rem_q <= '0;
      quo_q <= num_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o   = busy_q;
  assign done_o   = done_q;
  assign quo_o    = quo_q;
  assign rem_nz_o = |rem_q;

endmodule

// ===== hw/rtl/dtlr_front.sv =====
// ----------------------------------------------------------------------------
// Rasterizer front end
// Accepts command beats, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtlr_front #(
  parameter int unsigned SCREEN_WIDTH  = dtlr_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = dtlr_pkg::SCREEN_HEIGHT_DEF,
  parameter int unsigned VERTEX_COUNT  = dtlr_pkg::VERTEX_COUNT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  dtlr_pkg::cmd_t       cmd_i,
  output logic                 busy_o,
  input  dtlr_pkg::back_stat_t stat_i,
  output dtlr_pkg::head_t      head_o
);

  dtlr_pkg::job_t job_in;
  dtlr_pkg::job_t ent_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           full, push;

  // Classify: vertex index range and screen test of the position.
  always_comb begin
    job_in.cmd       = cmd_i;
    job_in.va_ok     = (32'(cmd_i.vertex_a) < VERTEX_COUNT);
    job_in.vb_ok     = (32'(cmd_i.vertex_b) < VERTEX_COUNT);
    job_in.on_screen = (32'(cmd_i.pos_x[dtlr_pkg::POS_W-1:4]) < SCREEN_WIDTH) &&
                       (32'(cmd_i.pos_y[dtlr_pkg::POS_W-1:4]) < SCREEN_HEIGHT);
  end

  assign full   = (cnt_q == 2'd2);
  assign busy_o = full || stat_i.clearing;
  assign push   = start_i && !busy_o;

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (stat_i.pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !stat_i.pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (!push && stat_i.pop) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= job_in;
    end
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.job   = ent_q[rd_ptr_q];

endmodule

// ===== hw/rtl/dtlr_back.sv =====
// ----------------------------------------------------------------------------
// Rasterizer back end
// Sequencer that runs one command at a time against the vertex store and the
// pixel buffer: line setup, three divisions and the per-pixel depth walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtlr_back #(
  parameter int unsigned SCREEN_WIDTH       = dtlr_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT      = dtlr_pkg::SCREEN_HEIGHT_DEF,
  parameter int unsigned VERTEX_COUNT       = dtlr_pkg::VERTEX_COUNT_DEF,
  parameter int unsigned STEP_FRACTION_BITS = dtlr_pkg::STEP_FRACTION_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dtlr_pkg::head_t              head_i,
  output dtlr_pkg::back_stat_t         stat_o,
  input  logic [dtlr_pkg::CFG_W-1:0]   depth_scale_i,
  input  logic [dtlr_pkg::CFG_W-1:0]   depth_offset_i,
  output logic                         done_o,
  output dtlr_pkg::result_t            result_o
);

  localparam int unsigned PIX_CNT = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int unsigned PAW     = $clog2(PIX_CNT);
  localparam int unsigned VAW     = $clog2(VERTEX_COUNT);
  localparam int unsigned SFB     = STEP_FRACTION_BITS;
  localparam int unsigned FW      = SFB + 2;
  localparam int unsigned NW      = dtlr_pkg::DIV_NUM_W;
  localparam int unsigned ZW      = dtlr_pkg::ZACC_W;
  localparam int unsigned PW      = dtlr_pkg::POS_W;

  typedef enum logic [21:0] {
    ST_CLEAR   = 22'h000001,
    ST_IDLE    = 22'h000002,
    ST_LOAD    = 22'h000004,
    ST_VRD_A   = 22'h000008,
    ST_VRD_B   = 22'h000010,
    ST_VCAP    = 22'h000020,
    ST_SETUP   = 22'h000040,
    ST_ZMUL_S  = 22'h000080,
    ST_ZMUL_E  = 22'h000100,
    ST_ZCAP    = 22'h000200,
    ST_ZDIFF   = 22'h000400,
    ST_DIV_Z   = 22'h000800,
    ST_DIV_DZ  = 22'h001000,
    ST_DIV_MIN = 22'h002000,
    ST_WALK_RD = 22'h004000,
    ST_WALK_WR = 22'h008000,
    ST_PT_MUL  = 22'h010000,
    ST_PT_RD   = 22'h020000,
    ST_PT_WR   = 22'h040000,
    ST_RD_RD   = 22'h080000,
    ST_RD_CAP  = 22'h100000,
    ST_DONE    = 22'h200000
  } state_e;

  state_e state_q, state_d;

  // Command and result registers.
  dtlr_pkg::job_t    job_q;
  dtlr_pkg::result_t res_q;
  dtlr_pkg::result_t res_init;

  // Clearing sweep.
  logic [PAW-1:0] clr_cnt_q;

  // Vertex store and pixel buffer ports.
  logic                        vtx_we;
  logic [VAW-1:0]              vtx_waddr, vtx_raddr;
  logic [dtlr_pkg::VTX_W-1:0]  vtx_wdata, vtx_rdata;
  logic                        pix_we;
  logic [PAW-1:0]              pix_waddr, pix_addr, walk_addr, job_addr;
  logic [dtlr_pkg::PIX_W-1:0]  pix_wdata, pix_rdata;
  logic [31:0]                 walk_idx, job_idx;

  // Line setup.
  logic [dtlr_pkg::VTX_W-1:0]  vtx_a_q, vtx_b_q;
  logic [PW-1:0]               ax, ay, bx, by, s, e, m, vs_mn, ve_mn;
  logic [15:0]                 az, bz, vs_z, ve_z;
  logic signed [PW:0]          dx, dy, len, md;
  logic [PW-1:0]               adx, ady;
  logic                        major_x, swap, clip, line_skip;
  logic [PW:0]                 s_plus;
  logic [PW-1:0]               e_minus;
  logic [PW:0]                 corr_full;

  logic                        major_x_q;
  logic [9:0]                  major_q, snap_e_q;
  logic [4:0]                  corr_q;
  logic [dtlr_pkg::LEN_W-1:0]  len_q;
  logic signed [PW:0]          md_q;
  logic signed [10:0]          minor_q;
  logic [SFB-1:0]              frac_q;
  logic [15:0]                 zs_src_q, ze_src_q;

  // Depth setup.
  logic [dtlr_pkg::MUL_W-1:0]  mul_q;
  logic [15:0]                 mul_a;
  logic [32:0]                 zs_q, ze_q, z_scaled;
  logic signed [33:0]          diff_q;
  logic signed [ZW-1:0]        z_q;
  logic signed [NW-1:0]        dz_q;
  logic signed [FW-1:0]        dmin_q;

  // Divider hookup.
  logic                        div_go_q, div_start, div_busy, div_done, div_rem_nz;
  logic signed [NW-1:0]        div_num, diff_ext;
  logic [NW-1:0]               div_mag, div_quo;
  logic                        div_neg, div_state;
  logic signed [NW-1:0]        q_trunc, q_floor;

  // Walk.
  logic signed [10:0]          px, py;
  logic                        on_px;
  logic [31:0]                 zc;
  logic [15:0]                 st_depth;
  logic                        line_pass, pt_pass;
  logic signed [FW-1:0]        frac_sum;
  logic                        frac_wrap;

  // ------------------------------------------------------------------------
  // Storage
  // ------------------------------------------------------------------------
  dtlr_ram #(
    .WIDTH (dtlr_pkg::VTX_W),
    .DEPTH (VERTEX_COUNT)
  ) u_vtx_ram (
    .clk_i   (clk_i),
    .we_i    (vtx_we),
    .waddr_i (vtx_waddr),
    .wdata_i (vtx_wdata),
    .raddr_i (vtx_raddr),
    .rdata_o (vtx_rdata)
  );

  dtlr_ram #(
    .WIDTH (dtlr_pkg::PIX_W),
    .DEPTH (PIX_CNT)
  ) u_pix_ram (
    .clk_i   (clk_i),
    .we_i    (pix_we),
    .waddr_i (pix_waddr),
    .wdata_i (pix_wdata),
    .raddr_i (pix_addr),
    .rdata_o (pix_rdata)
  );

  dtlr_div #(
    .NUM_W (NW),
    .DEN_W (dtlr_pkg::LEN_W)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (div_mag),
    .den_i    (len_q),
    .busy_o   (div_busy),
    .done_o   (div_done),
    .quo_o    (div_quo),
    .rem_nz_o (div_rem_nz)
  );

  // Vertex store: load writes x, y and z in one word.
  assign vtx_we    = (state_q == ST_LOAD);
  assign vtx_waddr = VAW'(job_q.cmd.vertex_a);
  assign vtx_wdata = {job_q.cmd.depth_in, job_q.cmd.pos_y, job_q.cmd.pos_x};
  assign vtx_raddr = (state_q == ST_VRD_A) ? VAW'(job_q.cmd.vertex_a)
                                           : VAW'(job_q.cmd.vertex_b);

  // ------------------------------------------------------------------------
  // Line setup from both endpoints
  // ------------------------------------------------------------------------
  always_comb begin
    ax = vtx_a_q[PW-1:0];
    ay = vtx_a_q[2*PW-1:PW];
    az = vtx_a_q[dtlr_pkg::VTX_W-1:2*PW];
    bx = vtx_b_q[PW-1:0];
    by = vtx_b_q[2*PW-1:PW];
    bz = vtx_b_q[dtlr_pkg::VTX_W-1:2*PW];

    clip = (32'(ax) >= SCREEN_WIDTH * 16) || (32'(bx) >= SCREEN_WIDTH * 16) ||
           (32'(ay) >= SCREEN_HEIGHT * 16) || (32'(by) >= SCREEN_HEIGHT * 16);

    dx  = $signed({1'b0, bx}) - $signed({1'b0, ax});
    dy  = $signed({1'b0, by}) - $signed({1'b0, ay});
    adx = dx[PW] ? PW'(-dx) : dx[PW-1:0];
    ady = dy[PW] ? PW'(-dy) : dy[PW-1:0];
    major_x = (adx > ady);
    swap    = major_x ? !(dx > 0) : !(dy > 0);

    // Start vertex is the one with the smaller major coordinate.
    s     = major_x ? (swap ? bx : ax) : (swap ? by : ay);
    e     = major_x ? (swap ? ax : bx) : (swap ? ay : by);
    vs_mn = major_x ? (swap ? by : ay) : (swap ? bx : ax);
    ve_mn = major_x ? (swap ? ay : by) : (swap ? ax : bx);
    m     = vs_mn;
    vs_z  = swap ? bz : az;
    ve_z  = swap ? az : bz;
    md    = $signed({1'b0, ve_mn}) - $signed({1'b0, vs_mn});
    len   = $signed({1'b0, e}) - $signed({1'b0, s});

    line_skip = clip || (len <= 0) || (e < PW'(8));

    // Endpoints snap at half pixels; corr is the start offset in 1/16 pixel.
    s_plus    = {1'b0, s} + (PW+1)'(8);
    e_minus   = e - PW'(8);
    corr_full = {s_plus[PW:4], 4'b0000} + (PW+1)'(8) - {1'b0, s};
  end

  // ------------------------------------------------------------------------
  // Depth scaling multiplier, registered
  // ------------------------------------------------------------------------
  always_comb begin
    case (state_q)
      ST_ZMUL_S: mul_a = zs_src_q;
      ST_ZMUL_E: mul_a = ze_src_q;
      default:   mul_a = job_q.cmd.depth_in;
    endcase
  end

  assign z_scaled = {1'b0, mul_q[dtlr_pkg::MUL_W-1:16]} + {1'b0, depth_offset_i};

  // ------------------------------------------------------------------------
  // Divider operand selection and sign handling
  // ------------------------------------------------------------------------
  assign diff_ext  = {{(NW-34){diff_q[33]}}, diff_q};
  assign div_state = (state_q == ST_DIV_Z) || (state_q == ST_DIV_DZ) ||
                     (state_q == ST_DIV_MIN);

  always_comb begin
    case (state_q)
      ST_DIV_Z:  div_num = diff_ext * $signed({{(NW-5){1'b0}}, corr_q});
      ST_DIV_DZ: div_num = diff_ext <<< 4;
      default:   div_num = $signed({{(NW-PW-1){md_q[PW]}}, md_q}) <<< SFB;
    endcase
    div_neg = div_num[NW-1];
    div_mag = div_neg ? NW'(-div_num) : NW'(div_num);
    q_trunc = div_neg ? -$signed(div_quo) : $signed(div_quo);
    q_floor = div_neg ? -($signed(div_quo) + $signed(NW'(div_rem_nz)))
                      : $signed(div_quo);
  end

  assign div_start = div_state && !div_go_q;

  // ------------------------------------------------------------------------
  // Pixel addressing and depth tests
  // ------------------------------------------------------------------------
  always_comb begin
    px    = major_x_q ? $signed({1'b0, major_q}) : minor_q;
    py    = major_x_q ? minor_q : $signed({1'b0, major_q});
    on_px = !px[10] && !py[10] && (32'(px[9:0]) < SCREEN_WIDTH) &&
            (32'(py[9:0]) < SCREEN_HEIGHT);

    walk_idx  = 32'(py[9:0]) * SCREEN_WIDTH + 32'(px[9:0]);
    job_idx   = 32'(job_q.cmd.pos_y[PW-1:4]) * SCREEN_WIDTH +
                32'(job_q.cmd.pos_x[PW-1:4]);
    walk_addr = walk_idx[PAW-1:0];
    job_addr  = job_idx[PAW-1:0];
    pix_addr  = ((state_q == ST_WALK_RD) || (state_q == ST_WALK_WR)) ? walk_addr
                                                                     : job_addr;

    // Running depth saturated to 32 bits.
    if (z_q[ZW-1]) begin
      zc = '0;
    end else if (|z_q[ZW-2:32]) begin
      zc = '1;
    end else begin
      zc = z_q[31:0];
    end

    st_depth  = pix_rdata[dtlr_pkg::PIX_W-1:dtlr_pkg::COLOR_W];
    line_pass = (zc < {st_depth, st_depth});
    pt_pass   = (mul_q[dtlr_pkg::MUL_W-1:16] < {st_depth, 16'h0000});

    // Minor axis accumulator step.
    frac_sum  = $signed({2'b00, frac_q}) + dmin_q;
    frac_wrap = frac_sum[FW-1] || frac_sum[FW-2];
  end

  // Pixel buffer write: clearing sweep, line pixel or point.
  always_comb begin
    pix_waddr = pix_addr;
    pix_wdata = {zc[31:16], job_q.cmd.color_in};
    pix_we    = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        pix_waddr = clr_cnt_q;
        pix_wdata = {{dtlr_pkg::DEPTH_W{1'b1}}, {dtlr_pkg::COLOR_W{1'b0}}};
        pix_we    = 1'b1;
      end
      ST_WALK_WR: begin
        pix_we = on_px && line_pass;
      end
      ST_PT_WR: begin
        pix_wdata = {mul_q[dtlr_pkg::MUL_W-1:32], job_q.cmd.color_in};
        pix_we    = pt_pass;
      end
      default: ;
    endcase
  end

  // Starting result for the command at the queue head.
  always_comb begin
    res_init = '0;
    if (head_i.job.cmd.mode == dtlr_pkg::MODE_READ && !head_i.job.on_screen) begin
      res_init.read_depth = '1;
    end
    if (head_i.job.cmd.mode == dtlr_pkg::MODE_LINE &&
        !(head_i.job.va_ok && head_i.job.vb_ok)) begin
      res_init.skipped = 1'b1;
    end
  end

  // ------------------------------------------------------------------------
  // Sequencer next state
  // ------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == PAW'(PIX_CNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (head_i.valid) begin
          unique case (head_i.job.cmd.mode)
            dtlr_pkg::MODE_LOAD:  state_d = head_i.job.va_ok ? ST_LOAD : ST_DONE;
            dtlr_pkg::MODE_LINE:  state_d = (head_i.job.va_ok && head_i.job.vb_ok) ?
                                            ST_VRD_A : ST_DONE;
            dtlr_pkg::MODE_POINT: state_d = head_i.job.on_screen ? ST_PT_MUL : ST_DONE;
            dtlr_pkg::MODE_READ:  state_d = head_i.job.on_screen ? ST_RD_RD : ST_DONE;
            default:              state_d = ST_DONE;
          endcase
        end
      end
      ST_LOAD:    state_d = ST_DONE;
      ST_VRD_A:   state_d = ST_VRD_B;
      ST_VRD_B:   state_d = ST_VCAP;
      ST_VCAP:    state_d = ST_SETUP;
      ST_SETUP:   state_d = line_skip ? ST_DONE : ST_ZMUL_S;
      ST_ZMUL_S:  state_d = ST_ZMUL_E;
      ST_ZMUL_E:  state_d = ST_ZCAP;
      ST_ZCAP:    state_d = ST_ZDIFF;
      ST_ZDIFF:   state_d = ST_DIV_Z;
      ST_DIV_Z:   state_d = div_done ? ST_DIV_DZ : ST_DIV_Z;
      ST_DIV_DZ:  state_d = div_done ? ST_DIV_MIN : ST_DIV_DZ;
      ST_DIV_MIN: state_d = div_done ? ST_WALK_RD : ST_DIV_MIN;
      ST_WALK_RD: state_d = (major_q > snap_e_q) ? ST_DONE : ST_WALK_WR;
      ST_WALK_WR: state_d = ST_WALK_RD;
      ST_PT_MUL:  state_d = ST_PT_RD;
      ST_PT_RD:   state_d = ST_PT_WR;
      ST_PT_WR:   state_d = ST_DONE;
      ST_RD_RD:   state_d = ST_RD_CAP;
      ST_RD_CAP:  state_d = ST_DONE;
      ST_DONE:    state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      div_go_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (div_start) begin
        div_go_q <= 1'b1;
      end else if (div_done) begin
        div_go_q <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Datapath registers
  // ------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    mul_q <= dtlr_pkg::MUL_W'(mul_a) * dtlr_pkg::MUL_W'(depth_scale_i);
    case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          job_q <= head_i.job;
          res_q <= res_init;
        end
      end
      ST_VRD_B: vtx_a_q <= vtx_rdata;
      ST_VCAP:  vtx_b_q <= vtx_rdata;
      ST_SETUP: begin
        res_q.skipped <= line_skip;
        major_x_q     <= major_x;
        major_q       <= 10'(s_plus[PW:4]);
        snap_e_q      <= 10'(e_minus[PW-1:4]);
        corr_q        <= corr_full[4:0];
        len_q         <= len[PW-1:0];
        md_q          <= md;
        minor_q       <= $signed({3'b000, m[PW-1:4]});
        frac_q        <= {m[3:0], {(SFB-4){1'b0}}};
        zs_src_q      <= vs_z;
        ze_src_q      <= ve_z;
      end
      ST_ZMUL_E: zs_q   <= z_scaled;
      ST_ZCAP:   ze_q   <= z_scaled;
      ST_ZDIFF:  diff_q <= $signed({1'b0, ze_q}) - $signed({1'b0, zs_q});
      ST_DIV_Z: begin
        if (div_done) begin
          z_q <= $signed({{(ZW-33){1'b0}}, zs_q}) + ZW'(q_floor);
        end
      end
      ST_DIV_DZ: begin
        if (div_done) begin
          dz_q <= q_trunc;
        end
      end
      ST_DIV_MIN: begin
        if (div_done) begin
          dmin_q <= q_trunc[FW-1:0];
        end
      end
      ST_WALK_WR: begin
        if (on_px && line_pass) begin
          res_q.pixels_written <= res_q.pixels_written + 1'b1;
        end
        z_q     <= z_q + ZW'(dz_q);
        major_q <= major_q + 1'b1;
        frac_q  <= frac_sum[SFB-1:0];
        if (frac_wrap) begin
          minor_q <= md_q[PW] ? minor_q - 11'sd1 : minor_q + 11'sd1;
        end
      end
      ST_PT_WR: begin
        if (pt_pass) begin
          res_q.pixels_written <= dtlr_pkg::CNT_W'(1);
        end
      end
      ST_RD_CAP: begin
        res_q.read_color <= pix_rdata[dtlr_pkg::COLOR_W-1:0];
        res_q.read_depth <= st_depth;
      end
      default: ;
    endcase
  end

  assign stat_o.pop      = (state_q == ST_IDLE) && head_i.valid;
  assign stat_o.clearing = (state_q == ST_CLEAR);
  assign done_o          = (state_q == ST_DONE);
  assign result_o        = res_q;

  // ------------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------------
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.pop |-> head_i.valid)
    else $error("queue popped while empty");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_skip_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.skipped) |-> (result_o.pixels_written == '0))
    else $error("skipped line reports written pixels");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.clearing |-> (!done_o && !stat_o.pop))
    else $error("work done during clearing sweep");

endmodule

// ===== hw/rtl/depth_tested_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// Depth-tested line rasterizer
// Vertex table, 16-bit depth buffer and 16-bit color buffer with load, point,
// line and read-back commands.
//
// Channel   Handshake           Payload
// command   start_i / busy_o    cmd_i     (accepted when start_i && !busy_o)
// result    done_o              result_o  (one beat per command, one cycle)
// config    cfg_we_i            cfg_idx_i, cfg_wdata_i
//
// A line runs its setup with three divisions in the shared divider, then a
// pixel read-modify-write on the pixel buffer for each major-axis step.
// After reset every pixel buffer entry is cleared with busy_o high; config
// writes still land. Up to two commands queue ahead of the sequencer;
// results cannot stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module depth_tested_line_rasterizer #(
  parameter int unsigned SCREEN_WIDTH       = dtlr_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT      = dtlr_pkg::SCREEN_HEIGHT_DEF,
  parameter int unsigned VERTEX_COUNT       = dtlr_pkg::VERTEX_COUNT_DEF,
  parameter int unsigned STEP_FRACTION_BITS = dtlr_pkg::STEP_FRACTION_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  dtlr_pkg::cmd_t                 cmd_i,
  output logic                           busy_o,
  output logic                           done_o,
  output dtlr_pkg::result_t              result_o,
  input  logic                           cfg_we_i,
  input  logic [dtlr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dtlr_pkg::CFG_W-1:0]     cfg_wdata_i
);

  logic [dtlr_pkg::CFG_W-1:0] depth_scale_q, depth_offset_q;
  dtlr_pkg::head_t            head;
  dtlr_pkg::back_stat_t       stat;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_scale_q  <= '1;
      depth_offset_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dtlr_pkg::CFG_DEPTH_SCALE:  depth_scale_q  <= cfg_wdata_i;
        dtlr_pkg::CFG_DEPTH_OFFSET: depth_offset_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  dtlr_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .VERTEX_COUNT  (VERTEX_COUNT)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .cmd_i   (cmd_i),
    .busy_o  (busy_o),
    .stat_i  (stat),
    .head_o  (head)
  );

  dtlr_back #(
    .SCREEN_WIDTH       (SCREEN_WIDTH),
    .SCREEN_HEIGHT      (SCREEN_HEIGHT),
    .VERTEX_COUNT       (VERTEX_COUNT),
    .STEP_FRACTION_BITS (STEP_FRACTION_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .stat_o         (stat),
    .depth_scale_i  (depth_scale_q),
    .depth_offset_i (depth_offset_q),
    .done_o         (done_o),
    .result_o       (result_o)
  );

endmodule
